### rtl/mspt_pkg.sv
// Package for the multi-slot periodic timer: command codes, sequencer states
// and the request/result payload structs. No dependencies.
`timescale 1ns / 1ps

package mspt_pkg;

    localparam int DEF_NUM_SLOTS  = 8;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_POLL       = 3'd1;
    localparam logic [2:0] CMD_INIT       = 3'd2;
    localparam logic [2:0] CMD_START      = 3'd3;
    localparam logic [2:0] CMD_INIT_START = 3'd4;
    localparam logic [2:0] CMD_STOP       = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POLL,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [31:0] period;
        logic [15:0] repeat_count;
    } t_request;

    typedef struct packed {
        logic [2:0] result_slot;
        logic       expired;
        logic       status;
        logic       last;
    } t_result;

endpackage

### rtl/mspt_alu.sv
// Shared arithmetic unit of the timer sequencer: deadline add, expiry compare
// and repeat-count decrement. Depends on mspt_pkg.
`timescale 1ns / 1ps

module mspt_alu
    import mspt_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic [31:0]           i_tick,
    input  logic [31:0]           i_addend,
    input  logic [31:0]           i_deadline,
    input  logic [COUNT_BITS-1:0] i_remaining,
    output logic [31:0]           o_sum,
    output logic                  o_due,
    output logic [COUNT_BITS-1:0] o_rem_dec,
    output logic                  o_rem_zero,
    output logic                  o_rem_dec_zero
);

    assign o_sum          = i_tick + i_addend;
    assign o_due          = i_tick >= i_deadline;
    assign o_rem_dec      = i_remaining - COUNT_BITS'(1);
    assign o_rem_zero     = i_remaining == '0;
    assign o_rem_dec_zero = i_remaining == COUNT_BITS'(1);

endmodule

### rtl/mspt_slot_mem.sv
// Slot table memory: period, deadline and remaining count per slot, one
// write and one registered read per cycle. Depends on mspt_pkg.
`timescale 1ns / 1ps

module mspt_slot_mem
    import mspt_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] i_wr_addr,
    input  logic [31:0]                    i_wr_period,
    input  logic [31:0]                    i_wr_deadline,
    input  logic [COUNT_BITS-1:0]          i_wr_remaining,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_period,
    output logic [31:0]                    o_rd_deadline,
    output logic [COUNT_BITS-1:0]          o_rd_remaining
);

    localparam int ENTRY_W = 64 + COUNT_BITS;

    logic [ENTRY_W-1:0]   r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_written;
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_rd_ok;
    logic [ENTRY_W-1:0]   rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_period, i_wr_deadline, i_wr_remaining};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_written[i_rd_addr];
        end
    end

    assign rd_entry       = r_rd_ok ? r_rd_data : '0;
    assign o_rd_period    = rd_entry[ENTRY_W-1 -: 32];
    assign o_rd_deadline  = rd_entry[ENTRY_W-33 -: 32];
    assign o_rd_remaining = rd_entry[COUNT_BITS-1:0];

endmodule

### rtl/multi_slot_periodic_timer.sv
// Top level of the multi-slot periodic timer: command sequencer, tick count
// and active bits. Depends on mspt_pkg, mspt_alu and mspt_slot_mem.
`timescale 1ns / 1ps

// Usage:
//   A request (i_req: cmd, slot, period, repeat_count) is taken at a rising
//   edge where start is high and busy is low.
//   tick:  advances the tick count in the accept cycle; no result, busy stays
//          low, so ticks may come every cycle.
//   init, start, init_start, stop: busy in ST_EXEC while the slot entry
//          is read and updated; the single result (last = 1) is on o_result
//          with o_strobe high in the cycle right after ST_EXEC.
//   poll:  walks the slots with one compare per cycle, then a flush state,
//          busy throughout; the memory read of the next slot overlaps the
//          update of the current one. Each expired slot gives one result; hold
//          it until the next expired slot or the end of the walk, so the final
//          one can carry last = 1. No expired slot means no result.
//   Codes 6 and 7 are ignored and give no result.
//   Results are strobed on o_strobe for exactly one cycle; the receiver cannot
//   stall them and must take each strobe.
//   Reset (synchronous, active low) clears the tick count, all active bits
//   and the written bits of the slot table, so every slot reads as zero.
module multi_slot_periodic_timer
    import mspt_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_req,
    output logic     busy,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state               r_state, n_state;
    t_request             r_req, n_req;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic                 r_pend_vld, n_pend_vld;
    logic [SLOT_W-1:0]    r_pend_slot, n_pend_slot;
    logic [31:0]          r_tick, n_tick;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic                 r_strobe, n_strobe;
    t_result              r_out, n_out;

    // Slot table access
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [31:0]           wr_period;
    logic [31:0]           wr_deadline;
    logic [COUNT_BITS-1:0] wr_remaining;
    logic [SLOT_W-1:0]     rd_addr;
    logic [31:0]           rd_period;
    logic [31:0]           rd_deadline;
    logic [COUNT_BITS-1:0] rd_remaining;

    // Shared unit
    logic [31:0]           alu_addend;
    logic [31:0]           alu_sum;
    logic                  alu_due;
    logic [COUNT_BITS-1:0] alu_rem_dec;
    logic                  alu_rem_zero;
    logic                  alu_rem_dec_zero;

    // Command decode helpers
    logic                  slot_ok;
    logic [SLOT_W-1:0]     req_idx;
    logic [COUNT_BITS-1:0] init_rem;
    logic                  status;
    logic                  idx_last;

    mspt_slot_mem #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_slot_mem (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_period    (wr_period),
        .i_wr_deadline  (wr_deadline),
        .i_wr_remaining (wr_remaining),
        .i_rd_addr      (rd_addr),
        .o_rd_period    (rd_period),
        .o_rd_deadline  (rd_deadline),
        .o_rd_remaining (rd_remaining)
    );

    mspt_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .i_tick         (r_tick),
        .i_addend       (alu_addend),
        .i_deadline     (rd_deadline),
        .i_remaining    (rd_remaining),
        .o_sum          (alu_sum),
        .o_due          (alu_due),
        .o_rem_dec      (alu_rem_dec),
        .o_rem_zero     (alu_rem_zero),
        .o_rem_dec_zero (alu_rem_dec_zero)
    );

    assign slot_ok  = 32'(r_req.slot) < NUM_SLOTS;
    assign req_idx  = SLOT_W'(r_req.slot);
    assign init_rem = COUNT_BITS'(r_req.repeat_count);
    assign idx_last = r_idx == SLOT_W'(NUM_SLOTS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_tick     <= '0;
            r_active   <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_tick     <= n_tick;
            r_active   <= n_active;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_pend_vld   = r_pend_vld;
        n_pend_slot  = r_pend_slot;
        n_tick       = r_tick;
        n_active     = r_active;
        n_strobe     = 1'b0;
        n_out        = r_out;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_period    = rd_period;
        wr_deadline  = rd_deadline;
        wr_remaining = rd_remaining;
        rd_addr      = '0;
        alu_addend   = rd_period;
        status       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // Read the addressed slot, or slot zero for a poll
                rd_addr = (i_req.cmd == CMD_POLL) ? '0 : SLOT_W'(i_req.slot);
                if (start) begin
                    unique case (i_req.cmd) inside
                        CMD_TICK: begin
                            n_tick = r_tick + 32'd1;
                        end
                        CMD_POLL: begin
                            n_idx      = '0;
                            n_pend_vld = 1'b0;
                            n_state    = ST_POLL;
                        end
                        CMD_INIT, CMD_START, CMD_INIT_START, CMD_STOP: begin
                            n_req   = i_req;
                            n_state = ST_EXEC;
                        end
                        default: begin
                            // drop unused codes
                        end
                    endcase
                end
            end

            ST_EXEC: begin
                wr_addr = req_idx;
                if (slot_ok) begin
                    unique case (r_req.cmd) inside
                        CMD_INIT: begin
                            wr_en        = 1'b1;
                            wr_period    = r_req.period;
                            wr_deadline  = '0;
                            wr_remaining = init_rem;
                        end
                        CMD_START: begin
                            if (r_active[req_idx]) begin
                                status = 1'b1;
                            end else begin
                                wr_en             = 1'b1;
                                wr_deadline       = alu_sum;
                                n_active[req_idx] = 1'b1;
                            end
                        end
                        CMD_INIT_START: begin
                            alu_addend   = r_req.period;
                            wr_en        = 1'b1;
                            wr_period    = r_req.period;
                            wr_remaining = init_rem;
                            if (r_active[req_idx]) begin
                                // init holds, start refused
                                wr_deadline = '0;
                                status      = 1'b1;
                            end else begin
                                wr_deadline       = alu_sum;
                                n_active[req_idx] = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            n_active[req_idx] = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                n_strobe = 1'b1;
                n_out    = '{result_slot: r_req.slot, expired: 1'b0,
                             status: status, last: 1'b1};
                n_state  = ST_IDLE;
            end

            ST_POLL: begin
                // Prefetch the next slot while the current one updates
                rd_addr = idx_last ? '0 : r_idx + SLOT_W'(1);
                wr_addr = r_idx;
                if (r_active[r_idx] && alu_due) begin
                    wr_en = 1'b1;
                    if (alu_rem_zero) begin
                        wr_deadline = alu_sum;
                    end else begin
                        wr_remaining = alu_rem_dec;
                        if (alu_rem_dec_zero) begin
                            n_active[r_idx] = 1'b0;
                        end else begin
                            wr_deadline = alu_sum;
                        end
                    end
                    // Release the previous expiry; it is not the final one
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_out    = '{result_slot: 3'(r_pend_slot), expired: 1'b1,
                                     status: 1'b0, last: 1'b0};
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_slot = r_idx;
                end
                if (idx_last) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            ST_FLUSH: begin
                if (r_pend_vld) begin
                    n_strobe = 1'b1;
                    n_out    = '{result_slot: 3'(r_pend_slot), expired: 1'b1,
                                 status: 1'b0, last: 1'b1};
                end
                n_pend_vld = 1'b0;
                n_state    = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = r_state != ST_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
